/* sv/rpvg_pkg.sv */
// shared widths, register codes and trig tables of the polygon vertex generator
package rpvg_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int MAX_SIDES   = 32;
  localparam int MIN_SIDES   = 3;

  localparam int RADIUS_W = 12;
  localparam int OFFSET_W = 16;
  localparam int VERTEX_W = 17;
  localparam int SIDES_W  = 6;
  localparam int START_W  = 9;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;

  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 15;
  localparam int ANGLE_W = $clog2(ANGLE_STEPS);
  localparam int PH_W    = ((ANGLE_W > START_W) ? ANGLE_W : START_W) + 1;
  localparam int CNT_W   = $clog2(MAX_SIDES + 1);
  localparam int PROD_W  = RADIUS_W + 1 + TRIG_W;
  localparam int SUM_W   = ((PROD_W > OFFSET_W + FRAC_W) ? PROD_W : OFFSET_W + FRAC_W) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDES       = 1'b0,
    REG_START_ANGLE = 1'b1
  } cfg_reg_t;

  typedef logic signed [TRIG_W-1:0]  trig_tab_t  [ANGLE_STEPS];
  typedef logic        [ANGLE_W-1:0] delta_tab_t [2**CNT_W];

  // shift and subtract long division, used only while building tables
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned mod_u64(input longint unsigned num,
                                              input longint unsigned den);
    return num - div_u64(num, den) * den;
  endfunction

  // quarter-wave taylor series in q30, then round to q15
  function automatic logic signed [TRIG_W-1:0] sin_q15(input longint unsigned a);
    longint unsigned full;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint unsigned mag;
    longint          sum;
    full = 4 * longint'(ANGLE_STEPS);
    a    = mod_u64(a, full);
    q    = div_u64(a, longint'(ANGLE_STEPS));
    r    = mod_u64(a, longint'(ANGLE_STEPS));
    if (q[0]) begin
      r = longint'(ANGLE_STEPS) - r;
    end
    x    = div_u64(r * 64'd1686629713, longint'(ANGLE_STEPS));
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      div  = longint'((2 * n) * (2 * n + 1));
      term = div_u64((term * x2) >> 30, div);
      if (n[0] == 1'b1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (longint'(sum) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    if (q >= 2) begin
      return -TRIG_W'(mag);
    end
    return TRIG_W'(mag);
  endfunction

  function automatic trig_tab_t build_trig(input bit cosine);
    trig_tab_t t;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      t[k] = sin_q15(longint'(4 * k + (cosine ? ANGLE_STEPS : 0)));
    end
    return t;
  endfunction

  function automatic delta_tab_t build_delta();
    delta_tab_t t;
    int         n;
    for (int k = 0; k < 2**CNT_W; k++) begin
      n = k;
      if (n < MIN_SIDES) begin
        n = MIN_SIDES;
      end
      if (n > MAX_SIDES) begin
        n = MAX_SIDES;
      end
      t[k] = ANGLE_W'(div_u64(longint'(ANGLE_STEPS), longint'(n)));
    end
    return t;
  endfunction

  localparam trig_tab_t  SIN_TAB   = build_trig(1'b0);
  localparam trig_tab_t  COS_TAB   = build_trig(1'b1);
  localparam delta_tab_t DELTA_TAB = build_delta();

endpackage

/* sv/rpvg_if.sv */
// handshake channels for polygon requests and vertex results
interface rpvg_in_if import rpvg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [RADIUS_W-1:0] radius;
  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;

  modport source (output valid, radius, offset_x, offset_y, input ready);
  modport sink   (input valid, radius, offset_x, offset_y, output ready);
endinterface

interface rpvg_out_if import rpvg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VERTEX_W-1:0] vertex_x;
  logic signed [VERTEX_W-1:0] vertex_y;
  logic                       last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

/* sv/regular_polygon_vertex_generator_unit.sv */
// regular polygon vertex generator: angle sequencer, trig rom, multiply and offset pipeline
// each vertex is registered in the rom stage, product stage and output register
// one vertex per cycle unless out_vtx stalls; a polygon has clamp(sides, 3, 32) vertices;
// the next transaction is taken in the cycle the final vertex leaves the angle sequencer
// a stall on out_vtx holds every stage; nothing is dropped or repeated
// reset: sides = 3, start_angle = 0, pipeline empty; no clearing pass
module regular_polygon_vertex_generator_unit import rpvg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rpvg_in_if.sink              in_vtx,
  rpvg_out_if.source           out_vtx
);

  // configuration
  logic [SIDES_W-1:0] sides_r;
  logic [START_W-1:0] start_angle_r;

  // angle sequencer
  logic                       busy_r;
  logic [ANGLE_W-1:0]         phi_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           n_r;
  logic [ANGLE_W-1:0]         delta_r;
  logic [RADIUS_W-1:0]        radius_r;
  logic signed [OFFSET_W-1:0] ox_r;
  logic signed [OFFSET_W-1:0] oy_r;

  // rom stage
  logic                       s1_vld_r;
  logic signed [TRIG_W-1:0]   s1_sin_r;
  logic signed [TRIG_W-1:0]   s1_cos_r;
  logic [RADIUS_W-1:0]        s1_radius_r;
  logic signed [OFFSET_W-1:0] s1_ox_r;
  logic signed [OFFSET_W-1:0] s1_oy_r;
  logic                       s1_last_r;

  // product stage
  logic                       s2_vld_r;
  logic signed [PROD_W-1:0]   s2_px_r;
  logic signed [PROD_W-1:0]   s2_py_r;
  logic signed [OFFSET_W-1:0] s2_ox_r;
  logic signed [OFFSET_W-1:0] s2_oy_r;
  logic                       s2_last_r;

  // output register
  logic                       out_vld_r;
  logic signed [VERTEX_W-1:0] out_x_r;
  logic signed [VERTEX_W-1:0] out_y_r;
  logic                       out_last_r;

  logic                       en;
  logic                       last_now;
  logic                       issue;
  logic                       accept;
  logic [PH_W-1:0]            phi_sum;
  logic [ANGLE_W-1:0]         phi_nxt;
  logic [PH_W-1:0]            start_ext;
  logic [ANGLE_W-1:0]         start_red;
  logic [CNT_W-1:0]           n_clamp;
  logic signed [PROD_W-1:0]   px;
  logic signed [PROD_W-1:0]   py;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [SUM_W-1:0]    rnd_x;
  logic signed [SUM_W-1:0]    rnd_y;

  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_W) - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sides_r       <= SIDES_W'(MIN_SIDES);
      start_angle_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIDES:       sides_r       <= cfg_data[SIDES_W-1:0];
        REG_START_ANGLE: start_angle_r <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_vld_r || out_vtx.ready;
  assign last_now = (cnt_r == n_r - CNT_W'(1));
  assign issue    = busy_r && en;

  assign in_vtx.ready = en && (!busy_r || last_now);
  assign accept       = in_vtx.valid && in_vtx.ready;

  always_comb begin
    phi_sum = PH_W'(phi_r) + PH_W'(delta_r);
    if (phi_sum >= PH_W'(ANGLE_STEPS)) begin
      phi_nxt = ANGLE_W'(phi_sum - PH_W'(ANGLE_STEPS));
    end else begin
      phi_nxt = ANGLE_W'(phi_sum);
    end
    start_ext = PH_W'(start_angle_r);
    if (start_ext >= PH_W'(ANGLE_STEPS)) begin
      start_red = ANGLE_W'(start_ext - PH_W'(ANGLE_STEPS));
    end else begin
      start_red = ANGLE_W'(start_ext);
    end
    if (sides_r < SIDES_W'(MIN_SIDES)) begin
      n_clamp = CNT_W'(MIN_SIDES);
    end else if (sides_r > SIDES_W'(MAX_SIDES)) begin
      n_clamp = CNT_W'(MAX_SIDES);
    end else begin
      n_clamp = CNT_W'(sides_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (issue && last_now) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phi_r    <= start_red;
      cnt_r    <= '0;
      n_r      <= n_clamp;
      delta_r  <= DELTA_TAB[n_clamp];
      radius_r <= in_vtx.radius;
      ox_r     <= in_vtx.offset_x;
      oy_r     <= in_vtx.offset_y;
    end else if (issue) begin
      phi_r <= phi_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // trig rom read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sin_r    <= SIN_TAB[phi_r];
      s1_cos_r    <= COS_TAB[phi_r];
      s1_radius_r <= radius_r;
      s1_ox_r     <= ox_r;
      s1_oy_r     <= oy_r;
      s1_last_r   <= last_now;
    end
  end

  // scale by radius
  assign px = $signed({1'b0, s1_radius_r}) * s1_cos_r;
  assign py = $signed({1'b0, s1_radius_r}) * s1_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px_r   <= px;
      s2_py_r   <= py;
      s2_ox_r   <= s1_ox_r;
      s2_oy_r   <= s1_oy_r;
      s2_last_r <= s1_last_r;
    end
  end

  // add offset, truncate toward zero
  always_comb begin
    sum_x = SUM_W'(s2_px_r) + (SUM_W'(s2_ox_r) <<< FRAC_W);
    sum_y = SUM_W'(s2_py_r) + (SUM_W'(s2_oy_r) <<< FRAC_W);
    rnd_x = sum_x + (sum_x[SUM_W-1] ? TRUNC_BIAS : '0);
    rnd_y = sum_y + (sum_y[SUM_W-1] ? TRUNC_BIAS : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r    <= VERTEX_W'(rnd_x >>> FRAC_W);
      out_y_r    <= VERTEX_W'(rnd_y >>> FRAC_W);
      out_last_r <= s2_last_r;
    end
  end

  assign out_vtx.valid       = out_vld_r;
  assign out_vtx.vertex_x    = out_x_r;
  assign out_vtx.vertex_y    = out_y_r;
  assign out_vtx.last_vertex = out_last_r;

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!busy_r || issue && last_now))
    else $error("transaction taken while sequencer still has vertices to issue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && cnt_r == '0)
    else $error("sequencer not started after transaction");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < n_r) && (phi_r < ANGLE_W'(ANGLE_STEPS)))
    else $error("vertex count or angle out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s2_px_r) && $stable(s1_sin_r) && $stable(phi_r))
    else $error("pipeline moved during output stall");

endmodule
